>>> hdl/ute_pkg.sv
// Shared types and constants for the UTF-8 token estimator.
package ute_pkg;

   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned CpWidth    = 21;
   localparam int unsigned RemWidth   = 2;
   localparam int unsigned CountWidth = 32;

   localparam logic [CountWidth-1:0] CountMax = '1;

   // Whitespace code points that close a word
   localparam logic [CpWidth-1:0] CpSpace   = 21'h000020;
   localparam logic [CpWidth-1:0] CpNewline = 21'h00000A;
   localparam logic [CpWidth-1:0] CpTab     = 21'h000009;

   // Lead byte class masks and patterns
   localparam logic [ByteWidth-1:0] LeadAsciiMask = 8'h80;
   localparam logic [ByteWidth-1:0] Lead2Mask     = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead2Pat      = 8'hC0;
   localparam logic [ByteWidth-1:0] Lead2Payload  = 8'h1F;
   localparam logic [ByteWidth-1:0] Lead3Mask     = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead3Pat      = 8'hE0;
   localparam logic [ByteWidth-1:0] Lead3Payload  = 8'h0F;
   localparam logic [ByteWidth-1:0] Lead4Mask     = 8'hF8;
   localparam logic [ByteWidth-1:0] Lead4Pat      = 8'hF0;
   localparam logic [ByteWidth-1:0] Lead4Payload  = 8'h07;
   localparam logic [ByteWidth-1:0] ContPayload   = 8'h3F;

   // Decoder state carried from byte to byte
   typedef struct packed {
      logic [CpWidth-1:0]    acc;
      logic [RemWidth-1:0]   remaining;
      logic                  in_word;
      logic [CountWidth-1:0] count;
   } dec_state_type;

endpackage

>>> hdl/ute_decode.sv
// Per-byte UTF-8 decode, code point classification and saturating count update.
module ute_decode (
   input  logic [ute_pkg::ByteWidth-1:0] text_byte,
   input  logic                          end_of_text,
   input  ute_pkg::dec_state_type        state_cur,
   output ute_pkg::dec_state_type        state_nxt
);

   logic [ute_pkg::CpWidth-1:0]    cp;
   logic [ute_pkg::RemWidth-1:0]   extra;
   logic                           complete;
   logic                           is_space;
   logic                           is_high;
   logic [1:0]                     inc;
   logic                           in_word_nxt;
   logic [ute_pkg::CountWidth:0]   sum;

   // Build the code point from a lead byte or a following byte
   always_comb begin
      cp    = '0;
      extra = '0;
      if (state_cur.remaining == '0) begin
         priority if ((text_byte & ute_pkg::LeadAsciiMask) == '0) begin
            cp    = ute_pkg::CpWidth'(text_byte);
            extra = 2'd0;
         end else if ((text_byte & ute_pkg::Lead2Mask) == ute_pkg::Lead2Pat) begin
            cp    = ute_pkg::CpWidth'(text_byte & ute_pkg::Lead2Payload);
            extra = 2'd1;
         end else if ((text_byte & ute_pkg::Lead3Mask) == ute_pkg::Lead3Pat) begin
            cp    = ute_pkg::CpWidth'(text_byte & ute_pkg::Lead3Payload);
            extra = 2'd2;
         end else if ((text_byte & ute_pkg::Lead4Mask) == ute_pkg::Lead4Pat) begin
            cp    = ute_pkg::CpWidth'(text_byte & ute_pkg::Lead4Payload);
            extra = 2'd3;
         end else begin
            cp    = ute_pkg::CpWidth'(text_byte);
            extra = 2'd0;
         end
      end else begin
         cp    = {state_cur.acc[ute_pkg::CpWidth-7:0], text_byte[5:0]};
         extra = state_cur.remaining - 2'd1;
      end
   end

   assign complete = (extra == '0) || end_of_text;

   // Classify a finished code point
   assign is_space = (cp == ute_pkg::CpSpace) || (cp == ute_pkg::CpNewline) ||
                     (cp == ute_pkg::CpTab);
   assign is_high  = |cp[ute_pkg::CpWidth-1:7];

   always_comb begin
      inc         = 2'd0;
      in_word_nxt = state_cur.in_word;
      if (complete) begin
         priority if (is_space) begin
            in_word_nxt = 1'b0;
         end else if (is_high) begin
            in_word_nxt = 1'b0;
            inc         = state_cur.in_word ? 2'd2 : 2'd1;
         end else if (!state_cur.in_word) begin
            in_word_nxt = 1'b1;
            inc         = 2'd1;
         end else begin
            in_word_nxt = 1'b1;
         end
      end
   end

   // Saturating add of up to two
   assign sum = {1'b0, state_cur.count} + (ute_pkg::CountWidth+1)'(inc);

   always_comb begin
      state_nxt.in_word   = in_word_nxt;
      state_nxt.count     = sum[ute_pkg::CountWidth] ? ute_pkg::CountMax
                                                     : sum[ute_pkg::CountWidth-1:0];
      state_nxt.acc       = complete ? '0 : cp;
      state_nxt.remaining = complete ? '0 : extra;
   end

endmodule

>>> hdl/utf8_token_estimator_top.sv
// Top level of the UTF-8 token estimator: input register, decode, result register.
// The final byte passes the input register, then the result register, to rsp_.
// Throughput: one byte per cycle with combinational decode, unless rsp_ blocks.
// The input register refills in the cycle it drains, so bytes stream without gaps.
// Reset (synchronous, active high) empties both registers and zeroes decoder state.
module utf8_token_estimator_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // [31:0] token_count
);

   logic                          in_valid_ff;
   logic [ute_pkg::ByteWidth-1:0] in_byte_ff;
   logic                          in_last_ff;
   ute_pkg::dec_state_type        state_ff;
   ute_pkg::dec_state_type        state_in;
   logic                          out_valid_ff;
   logic [ute_pkg::CountWidth-1:0] out_count_ff;
   logic                          advance;

   // Advance the held byte unless it is final and the result register is blocked
   assign advance    = in_valid_ff && (!in_last_ff || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   ute_decode u_decode (
      .text_byte   (in_byte_ff),
      .end_of_text (in_last_ff),
      .state_cur   (state_ff),
      .state_nxt   (state_in)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Decoder state: clear after the final byte
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= in_last_ff ? '0 : state_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && in_last_ff) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_last_ff) begin
         out_count_ff <= state_in.count;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_count_ff;

endmodule
